### hdl/byte_range_header_parser_macros.svh
// assertion macros for the byte range header parser
// used by modules that carry concurrent checks; expects aclk and aresetn in scope
`ifndef BYTE_RANGE_HEADER_PARSER_MACROS_SVH
`define BYTE_RANGE_HEADER_PARSER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BRHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BRHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRHP_ASSERT_IMP(label, ante, cons, msg)
`define BRHP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hdl/brhp_pkg.sv
// types, constants and helper functions for the byte range header parser
// no dependencies
`default_nettype none
package brhp_pkg;

    localparam int OFFSET_BITS = 63;
    localparam int COUNT_BITS  = 16;
    localparam int CFG_ADDR_BITS = 3;

    // output request packing
    localparam int M_DATA_BITS  = 2 * OFFSET_BITS + COUNT_BITS + 2;
    localparam int M_TDATA_BITS = ((M_DATA_BITS + 7) / 8) * 8;

    // result queue geometry
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int QCNT_BITS = 3;

    // characters of interest
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_COMP = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RANGE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        WHY_NONE      = 2'd0,
        WHY_MALFORMED = 2'd1,
        WHY_UNSAT     = 2'd2
    } why_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FILE_SIZE   = 3'd0,
        REG_SUFFIX_EN   = 3'd1,
        REG_ALLOW_OPEN  = 3'd2,
        REG_DROP_BAD    = 3'd3,
        REG_RANGE_LIMIT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic    nonempty;
        offset_t value;
        logic    bad;
    } number_t;

    typedef struct packed {
        logic    seen_dash;
        number_t first;
        number_t second;
    } comp_t;

    typedef struct packed {
        why_t    why;
        offset_t start;
        offset_t last;
    } judge_t;

    typedef struct packed {
        kind_t   kind;
        offset_t start;
        offset_t last;
        count_t  count;
        why_t    why;
        logic    fin;
    } result_t;

    // append one character to a decimal number, flag non-digits and overflow
    function automatic number_t add_char(number_t n, logic [7:0] c);
        number_t                r;
        logic [OFFSET_BITS+3:0] wide;
        logic [OFFSET_BITS+3:0] prod;
        logic [3:0]             dig;
        r = n;
        r.nonempty = 1'b1;
        dig  = c[3:0];
        wide = (OFFSET_BITS+4)'(n.value);
        prod = (wide << 3) + (wide << 1) + (OFFSET_BITS+4)'(dig);
        if (!n.bad) begin
            if (c < CH_ZERO || c > CH_NINE) begin
                r.bad = 1'b1;
            end else if (prod[OFFSET_BITS+3:OFFSET_BITS] != 4'd0) begin
                r.bad = 1'b1;
            end else begin
                r.value = prod[OFFSET_BITS-1:0];
            end
        end
        return r;
    endfunction

    // normalize a finished component against the file size
    function automatic judge_t judge(comp_t cp, offset_t fs, logic suffix_en,
                                     logic allow_open);
        judge_t  j;
        offset_t n;
        offset_t lst;
        j.why   = WHY_NONE;
        j.start = '0;
        j.last  = '0;
        n   = (cp.second.value < fs) ? cp.second.value : fs;
        lst = fs - offset_t'(1);
        if (!cp.seen_dash) begin
            j.why = WHY_MALFORMED;
        end else if (!cp.first.nonempty) begin
            // suffix form
            if (!suffix_en || !cp.second.nonempty || cp.second.bad) begin
                j.why = WHY_MALFORMED;
            end else if (n == '0) begin
                j.why = WHY_UNSAT;
            end else begin
                j.start = fs - n;
                j.last  = lst;
            end
        end else begin
            // explicit or open-ended form
            if (cp.first.bad) begin
                j.why = WHY_MALFORMED;
            end else if (!cp.second.nonempty && !allow_open) begin
                j.why = WHY_MALFORMED;
            end else if (cp.second.nonempty && cp.second.bad) begin
                j.why = WHY_MALFORMED;
            end else if (cp.first.value >= fs) begin
                j.why = WHY_UNSAT;
            end else begin
                if (cp.second.nonempty && cp.second.value < lst) begin
                    lst = cp.second.value;
                end
                if (cp.first.value > lst) begin
                    j.why = WHY_MALFORMED;
                end else begin
                    j.start = cp.first.value;
                    j.last  = lst;
                end
            end
        end
        return j;
    endfunction

    function automatic result_t make_result(kind_t kind, offset_t start, offset_t last,
                                            count_t count, why_t why, logic fin);
        result_t r;
        r.kind  = kind;
        r.start = start;
        r.last  = last;
        r.count = count;
        r.why   = why;
        r.fin   = fin;
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/byte_range_header_parser.sv
// byte range header parser top level: input register, parse logic, result queue
// depends on brhp_pkg and byte_range_header_parser_macros.svh
`default_nettype none
// Parses an HTTP byte-ranges header value fed one character per input request
// (s_tdata = character, s_tuser = character present, s_tlast = end of header)
// and emits each accepted range, followed by a done or error request on m_.
// One input request is parsed per clock while the result queue has room for
// two results: it is held in the input register, is parsed by single-pass
// logic and its zero, one or two results are written into a four-entry result
// queue, from which they are presented on m_ in order; a request that yields
// two results places both in the queue. Configuration writes on
// cfg_wr_en/cfg_addr/cfg_wr_data take effect at once and are meant for idle
// periods only.
`include "byte_range_header_parser_macros.svh"
module byte_range_header_parser
    import brhp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration write port
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [OFFSET_BITS-1:0]   cfg_wr_data,
    // input stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // header_byte
    input  wire logic                     s_tuser,   // byte_present
    input  wire logic                     s_tlast,   // end_of_header
    // result stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]       m_tdata,   // range_start, range_last,
                                                     // range_count, fail_reason
    output logic [1:0]                    m_tuser,   // result_kind
    output logic                          m_tlast    // last_result
);

    // configuration registers
    offset_t file_size_reg;
    logic    suffix_en_reg;
    logic    allow_open_reg;
    logic    drop_bad_reg;
    count_t  range_limit_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_eoh_reg;

    // parser state
    phase_t phase_reg, phase_next;
    comp_t  comp_reg, comp_next;
    count_t cnt_reg, cnt_next;

    // results of the current request
    result_t    res0, res1;
    logic [1:0] nres;
    logic       fire;

    // result queue
    result_t              q_mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] q_count_reg;
    logic                 pop;
    result_t              head;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg    <= '0;
            suffix_en_reg    <= 1'b1;
            allow_open_reg   <= 1'b1;
            drop_bad_reg     <= 1'b0;
            range_limit_reg  <= count_t'(16);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FILE_SIZE:    file_size_reg    <= cfg_wr_data;
                REG_SUFFIX_EN:    suffix_en_reg    <= cfg_wr_data[0];
                REG_ALLOW_OPEN:   allow_open_reg   <= cfg_wr_data[0];
                REG_DROP_BAD:     drop_bad_reg     <= cfg_wr_data[0];
                REG_RANGE_LIMIT:  range_limit_reg  <= cfg_wr_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // parse fires when the queue has room for two results
    assign fire     = in_valid_reg && (q_count_reg <= QCNT_BITS'(QDEPTH - 2));
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_eoh_reg     <= s_tlast;
        end
    end

    // single-pass parse of one request
    always_comb begin
        phase_t  ph;
        comp_t   cp;
        count_t  cnt;
        logic    do_close;
        judge_t  jd;
        result_t r;
        ph       = phase_reg;
        cp       = comp_reg;
        cnt      = cnt_reg;
        do_close = 1'b0;
        nres     = 2'd0;
        res0     = '0;
        res1     = '0;
        jd       = '0;
        r        = '0;

        // limit already reached at the start of the request
        if (ph != PH_DONE && (in_present_reg || in_eoh_reg) && cnt >= range_limit_reg) begin
            res0 = make_result(KIND_DONE, '0, '0, cnt, WHY_NONE, 1'b1);
            nres = 2'd1;
            ph   = PH_DONE;
        end

        // character handling
        if (in_present_reg && ph != PH_DONE) begin
            if (ph == PH_SKIP && in_byte_reg == CH_SPACE) begin
                ph = PH_SKIP;
            end else if (in_byte_reg == CH_COMMA) begin
                do_close = 1'b1;
            end else begin
                ph = PH_COMP;
                if (in_byte_reg == CH_DASH && !cp.seen_dash) begin
                    cp.seen_dash = 1'b1;
                end else if (!cp.seen_dash) begin
                    cp.first = add_char(cp.first, in_byte_reg);
                end else begin
                    cp.second = add_char(cp.second, in_byte_reg);
                end
            end
        end

        // end of header closes an open component
        if (in_eoh_reg && ph == PH_COMP) begin
            do_close = 1'b1;
        end

        // close and judge the component
        if (do_close) begin
            jd = judge(cp, file_size_reg, suffix_en_reg, allow_open_reg);
            cp = '0;
            ph = PH_SKIP;
            if (jd.why == WHY_NONE) begin
                cnt  = count_t'(cnt + 1'b1);
                res0 = make_result(KIND_RANGE, jd.start, jd.last, cnt, WHY_NONE, 1'b0);
                nres = 2'd1;
                if (cnt >= range_limit_reg) begin
                    res1 = make_result(KIND_DONE, '0, '0, cnt, WHY_NONE, 1'b1);
                    nres = 2'd2;
                    ph   = PH_DONE;
                end
            end else if (!drop_bad_reg) begin
                res0 = make_result(KIND_ERROR, '0, '0, cnt, jd.why, 1'b1);
                nres = 2'd1;
                ph   = PH_DONE;
            end
        end

        // end of header: done unless already finished, then reset header state
        if (in_eoh_reg) begin
            if (ph != PH_DONE) begin
                r = make_result(KIND_DONE, '0, '0, cnt, WHY_NONE, 1'b1);
                if (nres == 2'd0) begin
                    res0 = r;
                end else begin
                    res1 = r;
                end
                nres = nres + 2'd1;
            end
            cp  = '0;
            ph  = PH_SKIP;
            cnt = '0;
        end

        phase_next = ph;
        comp_next  = cp;
        cnt_next   = cnt;
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            comp_reg  <= '0;
            cnt_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (fire && nres != 2'd0) begin
            q_mem_reg[wr_ptr_reg] <= res0;
        end
        if (fire && nres == 2'd2) begin
            q_mem_reg[QPTR_BITS'(wr_ptr_reg + 1'b1)] <= res1;
        end
    end

    assign pop = m_tvalid && m_tready;

    // result queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            if (fire) begin
                wr_ptr_reg <= QPTR_BITS'(wr_ptr_reg + nres);
            end
            if (pop) begin
                rd_ptr_reg <= QPTR_BITS'(rd_ptr_reg + 1'b1);
            end
            q_count_reg <= QCNT_BITS'(q_count_reg + (fire ? QCNT_BITS'(nres) : '0)
                                      - QCNT_BITS'(pop));
        end
    end

    // output request
    assign head     = q_mem_reg[rd_ptr_reg];
    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = M_TDATA_BITS'({head.why, head.count, head.last, head.start});
    assign m_tuser  = head.kind;
    assign m_tlast  = head.fin;

    // checks
    `BRHP_ASSERT_IMP(a_queue_bound, 1'b1, q_count_reg <= QCNT_BITS'(QDEPTH),
                     "result queue overflow")
    `BRHP_ASSERT_NEXT(a_result_shown, fire && nres != 2'd0, m_tvalid,
                      "parsed result not presented")
    `BRHP_ASSERT_NEXT(a_header_reset, fire && in_eoh_reg,
                      cnt_reg == '0 && phase_reg == PH_SKIP, "header state not cleared")
    `BRHP_ASSERT_IMP(a_error_reason, m_tvalid && head.kind == KIND_ERROR,
                     head.why != WHY_NONE, "error without reason")
    `BRHP_ASSERT_IMP(a_range_not_last, m_tvalid && head.kind == KIND_RANGE, !m_tlast,
                     "range marked last")

endmodule
`default_nettype wire
